>>> hdl/luhn_pkg.sv
// Shared constants and result codes for the Luhn card number checker.
`default_nettype none

package luhn_pkg;

  localparam int unsigned MAX_DIGITS = 16;
  localparam int unsigned MIN_DIGITS = 15;

  localparam int unsigned CNT_W   = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PREFIX_LEN = 6;
  localparam int unsigned PREFIX_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_SAT = 5'd31;
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_DIGITS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_NON_DIGIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BR_UNKNOWN    = 3'd0,
    BR_VISA       = 3'd1,
    BR_VISA_ELEC  = 3'd2,
    BR_MASTERCARD = 3'd3,
    BR_AMEX       = 3'd4,
    BR_DISCOVER   = 3'd5
  } brand_t;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

`default_nettype wire

>>> hdl/luhn_card_number_checker.sv
// Streaming Luhn mod-10 card number checker with card brand detection.
//
// Input channel s_*: one ASCII character per item in s_tdata[7:0];
// s_tlast marks the final character of a card number. Output channel m_*:
// one result item per number, sent after its final character.
// Each character goes through an input register and then a single pass of
// logic that updates the two Luhn sums, the count and the six-digit prefix.
// On the final character the same pass loads the result register.
// Throughput: one character per cycle while the result register is free; a
// final character is loaded into the input register and then waits there until
// the result register is free to take its result item.
// When the receiver stalls, the result register holds its item; characters
// of the next number keep flowing, and only a final character waits in the
// input register until the result register is free.
// Reset (rst, synchronous, active high) empties both registers and clears
// the count, the sums, the prefix and the non-digit flag.
`default_nettype none

module luhn_card_number_checker
  import luhn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [1:0] status, [4:2] card_brand, [9:5] digit_total
);

  // input register
  logic            in_valid;
  logic [7:0]      in_char;
  logic            in_last;

  // running state
  logic [CNT_W-1:0] char_count;
  digit_t           sum_even_doubled;
  digit_t           sum_odd_doubled;
  digit_t           prefix_digits [PREFIX_LEN];
  logic             non_digit_seen;

  // result register
  status_t          res_status;
  brand_t           res_brand;
  logic [CNT_W-1:0] res_total;

  logic out_free;
  logic st_fire;

  assign out_free = !m_tvalid || m_tready;
  assign st_fire  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || st_fire;

  function automatic digit_t add_mod10(digit_t a, digit_t b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) s = s - 5'd10;
    return s[DIGIT_W-1:0];
  endfunction

  // single-pass update
  logic             is_digit;
  digit_t           d;
  digit_t           dd;
  logic [CNT_W-1:0] count_next;
  digit_t           sum_even_next;
  digit_t           sum_odd_next;
  digit_t           prefix_next [PREFIX_LEN];
  logic             non_digit_next;
  digit_t           sum_sel;
  status_t          status_next;
  brand_t           brand_next;
  logic [9:0]       tail3;

  always_comb begin
    is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    d  = is_digit ? in_char[3:0] : 4'd0;
    dd = (d < 4'd5) ? 4'(d << 1) : 4'((d << 1) - 4'd9);

    sum_even_next = sum_even_doubled;
    sum_odd_next  = sum_odd_doubled;
    if (is_digit) begin
      if (!char_count[0]) begin
        sum_even_next = add_mod10(sum_even_doubled, dd);
        sum_odd_next  = add_mod10(sum_odd_doubled, d);
      end else begin
        sum_even_next = add_mod10(sum_even_doubled, d);
        sum_odd_next  = add_mod10(sum_odd_doubled, dd);
      end
    end

    for (int i = 0; i < PREFIX_LEN; i++) begin
      prefix_next[i] = prefix_digits[i];
    end
    if (char_count < CNT_W'(PREFIX_LEN)) begin
      prefix_next[char_count[PREFIX_IDX_W-1:0]] = d;
    end

    non_digit_next = non_digit_seen || !is_digit;
    count_next = (char_count < CNT_SAT) ? char_count + 5'd1 : char_count;

    // rightmost digit is never doubled: pick the sum by count parity
    sum_sel = count_next[0] ? sum_odd_next : sum_even_next;

    if (count_next < CNT_MIN || count_next > CNT_MAX) begin
      status_next = ST_BAD_LEN;
    end else if (non_digit_next) begin
      status_next = ST_NON_DIGIT;
    end else if (sum_sel != 4'd0) begin
      status_next = ST_BAD_SUM;
    end else begin
      status_next = ST_VALID;
    end

    tail3 = 10'(prefix_next[3]) * 10'd100 + 10'(prefix_next[4]) * 10'd10
          + 10'(prefix_next[5]);

    brand_next = BR_UNKNOWN;
    if (status_next == ST_VALID) begin
      if (prefix_next[0] == 4'd4) begin
        if ((prefix_next[1] == 4'd0 && prefix_next[2] == 4'd2 && prefix_next[3] == 4'd6) ||
            (prefix_next[1] == 4'd4 && prefix_next[2] == 4'd0 && prefix_next[3] == 4'd5) ||
            (prefix_next[1] == 4'd5 && prefix_next[2] == 4'd0 && prefix_next[3] == 4'd8) ||
            (prefix_next[1] == 4'd8 && prefix_next[2] == 4'd4 && prefix_next[3] == 4'd4) ||
            (prefix_next[1] == 4'd9 && prefix_next[2] == 4'd1 && prefix_next[3] == 4'd3) ||
            (prefix_next[1] == 4'd9 && prefix_next[2] == 4'd1 && prefix_next[3] == 4'd7) ||
            (prefix_next[1] == 4'd1 && prefix_next[2] == 4'd7 && prefix_next[3] == 4'd5 &&
             prefix_next[4] == 4'd0 && prefix_next[5] == 4'd0)) begin
          brand_next = BR_VISA_ELEC;
        end else begin
          brand_next = BR_VISA;
        end
      end else if (prefix_next[0] == 4'd5 && prefix_next[1] >= 4'd1 &&
                   prefix_next[1] <= 4'd5) begin
        brand_next = BR_MASTERCARD;
      end else if (prefix_next[0] == 4'd3 &&
                   (prefix_next[1] == 4'd4 || prefix_next[1] == 4'd7)) begin
        brand_next = BR_AMEX;
      end else if (prefix_next[0] == 4'd6 &&
                   (prefix_next[1] == 4'd5 ||
                    (prefix_next[1] == 4'd0 && prefix_next[2] == 4'd1 &&
                     prefix_next[3] == 4'd1) ||
                    (prefix_next[1] == 4'd4 && prefix_next[2] >= 4'd4) ||
                    (prefix_next[1] == 4'd2 && prefix_next[2] == 4'd2 &&
                     tail3 >= 10'd126 && tail3 <= 10'd925))) begin
        brand_next = BR_DISCOVER;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (st_fire) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // running state: clear after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count       <= '0;
      sum_even_doubled <= '0;
      sum_odd_doubled  <= '0;
      non_digit_seen   <= 1'b0;
      for (int i = 0; i < PREFIX_LEN; i++) prefix_digits[i] <= '0;
    end else if (st_fire) begin
      if (in_last) begin
        char_count       <= '0;
        sum_even_doubled <= '0;
        sum_odd_doubled  <= '0;
        non_digit_seen   <= 1'b0;
        for (int i = 0; i < PREFIX_LEN; i++) prefix_digits[i] <= '0;
      end else begin
        char_count       <= count_next;
        sum_even_doubled <= sum_even_next;
        sum_odd_doubled  <= sum_odd_next;
        non_digit_seen   <= non_digit_next;
        for (int i = 0; i < PREFIX_LEN; i++) prefix_digits[i] <= prefix_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st_fire && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (st_fire && in_last) begin
      res_status <= status_next;
      res_brand  <= brand_next;
      res_total  <= count_next;
    end
  end

  assign m_tdata = {6'd0, res_total, res_brand, res_status};

`ifndef SYNTHESIS
  a_brand_only_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_brand != BR_UNKNOWN |-> res_status == ST_VALID)
    else $error("brand set on a number that is not valid");

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_status != ST_BAD_LEN |-> res_total >= CNT_MIN && res_total <= CNT_MAX)
    else $error("length accepted outside the allowed range");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    st_fire && in_last |=> char_count == '0 && !non_digit_seen)
    else $error("state not cleared after a final character");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire

>>> verif/luhn_card_number_checker_tb.sv
// Self-checking testbench for the Luhn card number checker: random card numbers, gaps and stalls.
`default_nettype none

module luhn_card_number_checker_tb;
  import luhn_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_CHARS = 1200;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       hold;   // wait for every pending result before this item
    logic       quiet;  // no gaps or stalls while this item is in flight
  } char_item_t;

  typedef struct packed {
    status_t    status;
    brand_t     brand;
    logic [4:0] total;
  } card_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  luhn_card_number_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] char_code
    .s_tlast  (s_tlast),   // is_last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [1:0] status, [4:2] card_brand, [9:5] digit_total
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t   pending_chars[$];
  card_result_t pending_results[$];
  logic [7:0]   num_buf[$];
  char_item_t   next_char;
  card_result_t got_expect;

  // Shadow of the checker state
  logic [4:0] pos_count;
  logic [3:0] sum_dbl_even;
  logic [3:0] sum_dbl_odd;
  logic [3:0] lead_digits[6];
  logic       saw_non_digit;

  int results_due;
  int results_seen;
  int errors;
  int cycles;
  int send_gap;
  int rx_stall;
  int rx_gap;
  logic rx_quiet;
  int chars_sent;
  int numbers_queued;
  int random_chars;
  int status_hits[4];
  int brand_hits[6];

  function automatic int pick_gap(input logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] any_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  function automatic brand_t brand_from_lead();
    int unsigned lead[7];
    int unsigned acc;
    acc = 0;
    lead[0] = 0;
    for (int i = 0; i < 6; i++) begin
      acc = acc * 10 + lead_digits[i];
      lead[i + 1] = acc;
    end
    if (lead[1] == 4) begin
      if (lead[4] == 4026 || lead[4] == 4405 || lead[4] == 4508 || lead[4] == 4844 ||
          lead[4] == 4913 || lead[4] == 4917 || lead[6] == 417500)
        return BR_VISA_ELEC;
      return BR_VISA;
    end
    if (lead[2] >= 51 && lead[2] <= 55) return BR_MASTERCARD;
    if (lead[2] == 34 || lead[2] == 37) return BR_AMEX;
    if (lead[2] == 65 || lead[4] == 6011 || (lead[3] >= 644 && lead[3] <= 649) ||
        (lead[6] >= 622126 && lead[6] <= 622925))
      return BR_DISCOVER;
    return BR_UNKNOWN;
  endfunction

  // Advance the shadow state by one accepted character; queue a result on the last one.
  task automatic luhn_track(input logic [7:0] code, input logic last);
    int d;
    int dd;
    int n;
    logic [3:0] sum;
    card_result_t res;
    if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      d = code - CHAR_ZERO;
      dd = (2 * d >= 10) ? 2 * d - 9 : 2 * d;
      if (!pos_count[0]) begin
        sum_dbl_even = 4'((sum_dbl_even + dd) % 10);
        sum_dbl_odd  = 4'((sum_dbl_odd + d) % 10);
      end else begin
        sum_dbl_even = 4'((sum_dbl_even + d) % 10);
        sum_dbl_odd  = 4'((sum_dbl_odd + dd) % 10);
      end
      if (pos_count < 6) lead_digits[pos_count[2:0]] = 4'(d);
    end else begin
      saw_non_digit = 1'b1;
      if (pos_count < 6) lead_digits[pos_count[2:0]] = '0;
    end
    if (pos_count != CNT_SAT) pos_count = pos_count + 5'd1;
    if (last) begin
      n = pos_count;
      // the rightmost digit is never doubled, so the count parity picks the sum
      sum = n[0] ? sum_dbl_odd : sum_dbl_even;
      res.brand = BR_UNKNOWN;
      if (n < MIN_DIGITS || n > MAX_DIGITS) res.status = ST_BAD_LEN;
      else if (saw_non_digit) res.status = ST_NON_DIGIT;
      else if (sum != 0) res.status = ST_BAD_SUM;
      else begin
        res.status = ST_VALID;
        res.brand = brand_from_lead();
      end
      res.total = pos_count;
      pending_results.insert(pending_results.size(), res);
      results_due++;
      pos_count = '0;
      sum_dbl_even = '0;
      sum_dbl_odd = '0;
      saw_non_digit = 1'b0;
      for (int i = 0; i < 6; i++) lead_digits[i] = '0;
    end
  endtask

  task automatic queue_number(input logic hold, input logic quiet);
    char_item_t it;
    for (int i = 0; i < num_buf.size(); i++) begin
      it.code  = num_buf[i];
      it.last  = (i == num_buf.size() - 1);
      it.hold  = hold && (i == 0);
      it.quiet = quiet;
      pending_chars.insert(pending_chars.size(), it);
    end
    numbers_queued++;
  endtask

  task automatic add_lead(input int unsigned value, input int width);
    for (int i = width - 1; i >= 0; i--)
      num_buf.insert(num_buf.size(), 8'(CHAR_ZERO + (value / (10 ** i)) % 10));
  endtask

  // Pad with random digits and append the check digit that makes the sum come out zero.
  task automatic fill_valid(input int len);
    int sum;
    int d;
    while (num_buf.size() < len - 1)
      num_buf.insert(num_buf.size(), 8'(CHAR_ZERO + $urandom_range(0, 9)));
    sum = 0;
    for (int i = 0; i < len - 1; i++) begin
      d = num_buf[i] - CHAR_ZERO;
      if ((len - 1 - i) % 2 == 1) d = (2 * d >= 10) ? 2 * d - 9 : 2 * d;
      sum += d;
    end
    num_buf.insert(num_buf.size(), 8'(CHAR_ZERO + (10 - sum % 10) % 10));
  endtask

  task automatic add_brand_lead();
    int unsigned pick;
    case ($urandom_range(0, 9))
      0: add_lead(4, 1);
      1: begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: add_lead(4026, 4);
          1: add_lead(4405, 4);
          2: add_lead(4508, 4);
          3: add_lead(4844, 4);
          4: add_lead(4913, 4);
          5: add_lead(4917, 4);
          6: add_lead(417500, 6);
          7: add_lead(417501, 6);
          8: add_lead(4027, 4);
          default: add_lead(4916, 4);
        endcase
      end
      2: add_lead(50 + $urandom_range(0, 6), 2);
      3: add_lead(33 + $urandom_range(0, 5), 2);
      4: begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: add_lead(65, 2);
          1: add_lead(6011, 4);
          2: add_lead(6012, 4);
          3: add_lead(643, 3);
          4: add_lead(644, 3);
          5: add_lead(649, 3);
          6: add_lead(650, 3);
          default: add_lead(64, 2);
        endcase
      end
      5: begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: add_lead(622125, 6);
          1: add_lead(622126, 6);
          2: add_lead(622127, 6);
          3: add_lead(622924, 6);
          4: add_lead(622925, 6);
          5: add_lead(622926, 6);
          default: add_lead(622000 + $urandom_range(0, 999), 6);
        endcase
      end
      6: add_lead(6, 1);
      default: ;
    endcase
  endtask

  task automatic build_random_number(input int idx);
    int kind;
    int len;
    logic hold;
    logic quiet;
    num_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      len = ($urandom_range(0, 2) == 0) ? 15 : 16;
      add_brand_lead();
      fill_valid(len);
      if (kind >= 60 && kind < 70)
        begin
          int p;
          p = $urandom_range(0, len - 1);
          num_buf[p] = 8'(CHAR_ZERO + (num_buf[p] - CHAR_ZERO + $urandom_range(1, 9)) % 10);
        end
      else if (kind >= 70)
        num_buf[$urandom_range(0, len - 1)] = any_non_digit();
    end else if (kind < 90) begin
      len = ($urandom_range(0, 1) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 35);
      while (num_buf.size() < len)
        num_buf.insert(num_buf.size(), 8'(CHAR_ZERO + $urandom_range(0, 9)));
    end else begin
      len = $urandom_range(1, 40);
      while (num_buf.size() < len)
        num_buf.insert(num_buf.size(),
                       ($urandom_range(0, 9) < 7) ? 8'(CHAR_ZERO + $urandom_range(0, 9))
                                                  : 8'($urandom_range(0, 255)));
    end
    hold  = (idx == 0) || ($urandom_range(0, 29) == 0);
    quiet = (idx >= 20 && idx < 35) || (idx >= 60 && idx < 65);
    queue_number(hold, quiet);
    random_chars += num_buf.size();
  endtask

  // Driver: present pending characters, predict on each accepted one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        luhn_track(s_tdata, s_tlast);
        chars_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_chars.size() > 0 &&
                     !(pending_chars[0].hold && results_due != results_seen)) begin
          next_char = pending_chars.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_char.code;
          s_tlast  <= next_char.last;
          rx_quiet <= next_char.quiet;
          send_gap <= pick_gap(next_char.quiet);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_quiet) begin
      m_tready <= 1'b1;
    end else begin
      rx_gap = pick_gap(1'b0);
      if (rx_gap == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_stall <= rx_gap - 1;
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        got_expect = pending_results.pop_front();
        if (m_tdata[1:0] !== got_expect.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, got_expect.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[4:2] !== got_expect.brand) begin
          $display("%0t card_brand mismatch: expected %0d, actual %0d",
                   $time, got_expect.brand, m_tdata[4:2]);
          errors++;
        end
        if (m_tdata[9:5] !== got_expect.total) begin
          $display("%0t digit_total mismatch: expected %0d, actual %0d",
                   $time, got_expect.total, m_tdata[9:5]);
          errors++;
        end
        status_hits[got_expect.status]++;
        if (got_expect.status == ST_VALID) brand_hits[got_expect.brand]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("[luhn_card_number_checker] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    rx_quiet = 1'b0;
    pos_count = '0;
    sum_dbl_even = '0;
    sum_dbl_odd = '0;
    saw_non_digit = 1'b0;
    for (int i = 0; i < 6; i++) lead_digits[i] = '0;
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    for (int i = 0; i < 6; i++) brand_hits[i] = 0;
    results_due = 0;
    results_seen = 0;
    errors = 0;
    cycles = 0;
    chars_sent = 0;
    numbers_queued = 0;
    random_chars = 0;

    // Directed: code extremes as one-character numbers, digit boundaries, a valid number
    num_buf.delete();
    num_buf.insert(num_buf.size(), 8'hFF);
    queue_number(1'b0, 1'b0);
    num_buf.delete();
    num_buf.insert(num_buf.size(), 8'h00);
    queue_number(1'b0, 1'b0);
    num_buf.delete();
    num_buf.insert(num_buf.size(), CHAR_ZERO - 8'd1);
    num_buf.insert(num_buf.size(), CHAR_NINE + 8'd1);
    num_buf.insert(num_buf.size(), CHAR_ZERO);
    num_buf.insert(num_buf.size(), CHAR_NINE);
    queue_number(1'b0, 1'b0);
    num_buf.delete();
    add_lead(4917, 4);
    fill_valid(16);
    queue_number(1'b0, 1'b0);

    for (int idx = 0; random_chars < RANDOM_CHARS; idx++) build_random_number(idx);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid || results_due != results_seen)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d chars in %0d numbers; valid/sum/length/non-digit: %0d/%0d/%0d/%0d",
             chars_sent, numbers_queued, status_hits[ST_VALID], status_hits[ST_BAD_SUM],
             status_hits[ST_BAD_LEN], status_hits[ST_NON_DIGIT]);
    $display("Valid by brand unknown/Visa/Electron/MC/Amex/Discover: %0d/%0d/%0d/%0d/%0d/%0d",
             brand_hits[BR_UNKNOWN], brand_hits[BR_VISA], brand_hits[BR_VISA_ELEC],
             brand_hits[BR_MASTERCARD], brand_hits[BR_AMEX], brand_hits[BR_DISCOVER]);
    if (pending_results.size() != 0)
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
    if (errors == 0 && pending_results.size() == 0)
      $display("[luhn_card_number_checker] OK");
    else
      $display("[luhn_card_number_checker] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
